/* sv/psd_pkg.sv */
// Package with shared types and constants of the port scan detector.
package psd_pkg;

  localparam logic [1:0] KIND_TCP  = 2'd0;
  localparam logic [1:0] KIND_UDP  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_DROP = 2'd3;

  localparam logic [2:0] REG_WATCH_MODE   = 3'd0;
  localparam logic [2:0] REG_MY_ADDR      = 3'd1;
  localparam logic [2:0] REG_PORT_LIMIT   = 3'd2;
  localparam logic [2:0] REG_WEB_LIMIT    = 3'd3;
  localparam logic [2:0] REG_REPORT_SCANS = 3'd4;

  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] WEB_PORT    = 16'd80;
  localparam logic [31:0] SUBNET_MASK = 32'hffffff00;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] alert_src;
    logic [31:0] alert_dst;
    logic [7:0]  port_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  watch_mode;
    logic [31:0] my_addr;
    logic [15:0] port_limit;
    logic [15:0] web_limit;
    logic        report_scans;
  } cfg_t;

endpackage

/* sv/psd_regs.sv */
// Configuration register file of the port scan detector.
module psd_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output psd_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.watch_mode   <= 2'd0;
      cfg.my_addr      <= 32'd0;
      cfg.port_limit   <= 16'd7;
      cfg.web_limit    <= 16'd40;
      cfg.report_scans <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        psd_pkg::REG_WATCH_MODE:   cfg.watch_mode   <= cfg_data[1:0];
        psd_pkg::REG_MY_ADDR:      cfg.my_addr      <= cfg_data;
        psd_pkg::REG_PORT_LIMIT:   cfg.port_limit   <= cfg_data[15:0];
        psd_pkg::REG_WEB_LIMIT:    cfg.web_limit    <= cfg_data[15:0];
        psd_pkg::REG_REPORT_SCANS: cfg.report_scans <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/psd_core.sv */
// Sequencer with entry and port memories of the port scan detector.
module psd_core #(
  parameter int ENTRIES         = 32,
  parameter int PORTS_PER_ENTRY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  psd_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic               in_ipv4,
  input  logic [7:0]         in_proto,
  input  logic               in_rst,
  input  logic [31:0]        in_src,
  input  logic [31:0]        in_dst,
  input  logic [15:0]        in_sport,
  input  logic [15:0]        in_dport,
  output logic               res_valid,
  input  logic               res_ready,
  output psd_pkg::result_t   res
);

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = (PORTS_PER_ENTRY > 1) ? $clog2(PORTS_PER_ENTRY) : 1;
  localparam int SW = (ENTRIES * PORTS_PER_ENTRY > 1) ?
                      $clog2(ENTRIES * PORTS_PER_ENTRY) : 1;
  localparam logic [7:0] PMAX = 8'(PORTS_PER_ENTRY);
  localparam logic [EW-1:0] ELAST = EW'(ENTRIES - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SRCH  = 8'b00000010,
    S_DECID = 8'b00000100,
    S_PORTS = 8'b00001000,
    S_PCHK  = 8'b00010000,
    S_RPT   = 8'b00100000,
    S_RCHK  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  typedef struct packed {
    logic [31:0] dst;
    logic [31:0] src;
    logic        udp;
    logic [7:0]  ports;
    logic [31:0] web;
  } entry_t;

  entry_t          ent_mem [ENTRIES];
  logic [15:0]     port_mem [ENTRIES * PORTS_PER_ENTRY];
  logic [ENTRIES-1:0] valid;

  state_t          state;
  logic [EW-1:0]   idx;
  logic [PW-1:0]   pidx;
  entry_t          ent_rd;
  logic [15:0]     port_rd;
  logic [EW-1:0]   rd_idx;
  logic            free_found;
  logic [EW-1:0]   free_idx;
  logic [EW-1:0]   hit_idx;
  entry_t          hit_ent;
  logic            ent_we;
  logic [EW-1:0]   ent_wa;
  entry_t          ent_wd;
  logic            port_we;
  logic [SW-1:0]   port_wa;
  logic [15:0]     port_wd;
  logic [SW-1:0]   port_ra;
  logic            p_udp;
  logic [31:0]     p_src, p_dst;
  logic [15:0]     p_sport, p_dport;
  logic            keep, watched, ent_match;
  logic [31:0]     diff;
  logic [EW-1:0]   new_slot;
  logic            new_ent, drop, port_hit, port_end, port_add, alert, res_load;
  logic [31:0]     web_inc;

  always_comb begin
    case (cfg.watch_mode)
      2'd0:    watched = in_dst == cfg.my_addr;
      2'd1:    watched = (in_dst & psd_pkg::SUBNET_MASK) ==
                         (cfg.my_addr & psd_pkg::SUBNET_MASK);
      default: watched = 1'b1;
    endcase
  end

  assign keep = in_ipv4 && watched &&
                ((in_proto == psd_pkg::PROTO_TCP && !in_rst) ||
                 in_proto == psd_pkg::PROTO_UDP);

  assign in_ready = (state == S_IDLE) && !res_valid;
  assign ent_match = valid[rd_idx] && ent_rd.dst == p_dst &&
                     ent_rd.src == p_src && ent_rd.udp == p_udp;
  assign diff = 32'(ent_rd.ports) - ent_rd.web;
  assign port_ra = SW'(hit_idx) * SW'(PORTS_PER_ENTRY) + SW'(pidx);

  assign new_slot = free_found ? free_idx : rd_idx;
  assign new_ent  = state == S_DECID && !ent_match && rd_idx == ELAST &&
                    (free_found || !valid[rd_idx]);
  assign drop     = state == S_DECID && !ent_match && rd_idx == ELAST &&
                    !free_found && valid[rd_idx];
  assign port_hit = state == S_PCHK && port_rd == p_dport;
  assign port_end = state == S_PCHK && !port_hit &&
                    (8'(pidx) + 8'd1 >= hit_ent.ports);
  assign port_add = port_end && hit_ent.ports < PMAX;
  assign web_inc  = (p_sport == psd_pkg::WEB_PORT && ent_rd.web != 32'hffffffff) ?
                    ent_rd.web + 32'd1 : ent_rd.web;
  assign alert    = valid[rd_idx] && cfg.report_scans &&
                    (diff > 32'(cfg.port_limit) || ent_rd.web > 32'(cfg.web_limit));
  assign res_load = drop ||
                    (state == S_RCHK && (!res_valid || res_ready) && alert) ||
                    (state == S_OUT && (!res_valid || res_ready));

  assign ent_we  = new_ent || port_hit || port_end;
  assign ent_wa  = new_ent ? new_slot : hit_idx;
  assign port_we = new_ent || port_add;
  assign port_wa = new_ent ? SW'(new_slot) * SW'(PORTS_PER_ENTRY) :
                   SW'(hit_idx) * SW'(PORTS_PER_ENTRY) + SW'(hit_ent.ports);
  assign port_wd = p_dport;

  always_comb begin
    ent_wd = hit_ent;
    if (new_ent) begin
      ent_wd = '{dst: p_dst, src: p_src, udp: p_udp, ports: 8'd1, web: 32'd1};
    end else if (port_add) begin
      ent_wd.ports = hit_ent.ports + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_rd <= ent_mem[idx];
    rd_idx <= idx;
    if (port_we) port_mem[port_wa] <= port_wd;
    port_rd <= port_mem[port_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      res_valid <= 1'b0;
      idx       <= '0;
      pidx      <= '0;
    end else begin
      res_valid <= res_load || (res_valid && !res_ready);
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            p_udp   <= in_proto == psd_pkg::PROTO_UDP;
            p_src   <= in_src;
            p_dst   <= in_dst;
            p_sport <= in_sport;
            p_dport <= in_dport;
            idx     <= '0;
            free_found <= 1'b0;
            if (in_op) state <= S_RPT;
            else if (keep) state <= S_SRCH;
          end
        end
        S_SRCH: state <= S_DECID;
        S_DECID: begin
          if (ent_match) begin
            hit_idx <= rd_idx;
            hit_ent <= '{dst: ent_rd.dst, src: ent_rd.src, udp: ent_rd.udp,
                         ports: ent_rd.ports, web: web_inc};
            pidx  <= '0;
            state <= S_PORTS;
          end else begin
            if (!valid[rd_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (rd_idx == ELAST) begin
              if (new_ent) begin
                valid[new_slot] <= 1'b1;
              end else begin
                res <= '{kind: psd_pkg::KIND_DROP, alert_src: '0,
                         alert_dst: '0, port_count: '0, last: 1'b1};
              end
              state <= S_IDLE;
            end else begin
              idx   <= rd_idx + EW'(1);
              state <= S_SRCH;
            end
          end
        end
        S_PORTS: state <= S_PCHK;
        S_PCHK: begin
          if (port_hit || port_end) begin
            state <= S_IDLE;
          end else begin
            pidx  <= pidx + PW'(1);
            state <= S_PORTS;
          end
        end
        S_RPT: state <= S_RCHK;
        S_RCHK: begin
          if (!res_valid || res_ready) begin
            if (alert) begin
              res <= '{kind: ent_rd.udp ? psd_pkg::KIND_UDP : psd_pkg::KIND_TCP,
                       alert_src: ent_rd.src, alert_dst: ent_rd.dst,
                       port_count: ent_rd.ports, last: 1'b0};
            end
            if (rd_idx == ELAST) state <= S_OUT;
            else begin
              idx   <= rd_idx + EW'(1);
              state <= S_RPT;
            end
          end
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res   <= '{kind: psd_pkg::KIND_END, alert_src: '0,
                       alert_dst: '0, port_count: '0, last: 1'b1};
            valid <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/port_scan_detector_top.sv */
// Top level of the port scan detector.
// The slave stream takes one word per packet or report request; the master
// stream returns alerts, report end markers and table-full drops, with
// tlast on the final word caused by an input. The configuration port must be
// written only while the block is idle; the block itself does not enforce this.
// A packet walks the entry memory over ENTRIES entries, each through a read
// state and a decide state, and on a hit walks the port memory of that entry,
// each stored port through a read state and a check state, since both memories
// have registered reads. A report walks all entries through a read state and a
// check state, then emits the end marker, and waits on any stall of the receiver.
// One item is processed at a time; s_tready is low while an item is at work
// or a result waits. When the receiver stalls the result word holds and the
// report walk pauses. Reset clears the valid bits and the state, index and
// output-valid registers at once; no clearing pass is needed.
module port_scan_detector_top #(
  parameter int ENTRIES         = 32,
  parameter int PORTS_PER_ENTRY = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation, is_ipv4, ip_protocol, tcp_rst, src_addr, dst_addr,
  // src_port, dst_port, then zero fill
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // kind, alert_src, alert_dst, port_count, then zero fill
  output logic [79:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  psd_pkg::cfg_t    cfg;
  psd_pkg::result_t res;

  psd_regs u_regs (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  psd_core #(.ENTRIES(ENTRIES), .PORTS_PER_ENTRY(PORTS_PER_ENTRY)) u_core (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_op(s_tdata[0]), .in_ipv4(s_tdata[1]), .in_proto(s_tdata[9:2]),
    .in_rst(s_tdata[10]), .in_src(s_tdata[42:11]), .in_dst(s_tdata[74:43]),
    .in_sport(s_tdata[90:75]), .in_dport(s_tdata[106:91]),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
  );

  assign m_tdata = {6'd0, res.port_count, res.alert_dst, res.alert_src, res.kind};
  assign m_tlast = res.last;

endmodule

/* sv/psd_checker.sv */
// Port-level checker of the port scan detector, bound to the top level.
module psd_port_props (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == psd_pkg::KIND_END ||
                 m_tdata[1:0] == psd_pkg::KIND_DROP) |-> m_tlast)
    else $error("end or drop word without tlast");

  a_alert_notlast: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == psd_pkg::KIND_TCP ||
                 m_tdata[1:0] == psd_pkg::KIND_UDP) |-> !m_tlast)
    else $error("alert word with tlast");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input accepted while a result word waits");

endmodule

bind port_scan_detector_top psd_port_props u_psd_port_props (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

/* bench/psd_checker.sv */
// Scoreboard for the port scan detector: predicts result words and compares them.
`timescale 1ns / 100ps
module psd_checker #(
  parameter int ENTRIES         = 32,
  parameter int PORTS_PER_ENTRY = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [111:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [79:0]  m_tdata,
  input  logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           pending
);

  psd_pkg::cfg_t    regs;
  logic        tab_valid [ENTRIES];
  logic [31:0] tab_dst   [ENTRIES];
  logic [31:0] tab_src   [ENTRIES];
  logic        tab_udp   [ENTRIES];
  logic [31:0] tab_ports [ENTRIES];
  logic [31:0] tab_web   [ENTRIES];
  logic [15:0] seen_ports [ENTRIES*PORTS_PER_ENTRY];
  psd_pkg::result_t alerts_due [$];

  assign pending = alerts_due.size();

  function automatic void push(logic [1:0] k, logic [31:0] s, logic [31:0] d,
                               logic [7:0] c, logic l);
    psd_pkg::result_t r;
    r.kind = k; r.alert_src = s; r.alert_dst = d; r.port_count = c; r.last = l;
    alerts_due.push_back(r);
  endfunction

  function automatic logic is_watched(logic [31:0] d);
    if (regs.watch_mode >= 2) return 1'b1;
    if (regs.watch_mode == 1)
      return (d & psd_pkg::SUBNET_MASK) == (regs.my_addr & psd_pkg::SUBNET_MASK);
    return d == regs.my_addr;
  endfunction

  function automatic void scan_packet(logic [111:0] w);
    logic        ipv4, rst_flag, udp;
    logic [7:0]  proto;
    logic [31:0] src, dst, diff, c;
    logic [15:0] sport, dport;
    int          free_slot;
    int          base;
    ipv4 = w[1]; proto = w[9:2]; rst_flag = w[10];
    src = w[42:11]; dst = w[74:43]; sport = w[90:75]; dport = w[106:91];
    free_slot = -1;
    if (w[0]) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!tab_valid[i] || !regs.report_scans) continue;
        diff = tab_ports[i] - tab_web[i];
        if (diff > regs.port_limit || tab_web[i] > regs.web_limit)
          push(tab_udp[i] ? psd_pkg::KIND_UDP : psd_pkg::KIND_TCP, tab_src[i],
               tab_dst[i], tab_ports[i][7:0], 1'b0);
      end
      push(psd_pkg::KIND_END, '0, '0, '0, 1'b1);
      foreach (tab_valid[i]) tab_valid[i] = 1'b0;
      return;
    end
    if (!ipv4 || !is_watched(dst)) return;
    if (proto == psd_pkg::PROTO_TCP) begin
      if (rst_flag) return;
      udp = 1'b0;
    end else if (proto == psd_pkg::PROTO_UDP) begin
      udp = 1'b1;
    end else begin
      return;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (!tab_valid[i]) begin
        if (free_slot < 0) free_slot = i;
        continue;
      end
      if (tab_dst[i] == dst && tab_src[i] == src && tab_udp[i] == udp) begin
        c = tab_ports[i];
        base = i * PORTS_PER_ENTRY;
        if (sport == psd_pkg::WEB_PORT && tab_web[i] != 32'hffffffff) tab_web[i]++;
        for (int p = 0; p < c && p < PORTS_PER_ENTRY; p++)
          if (seen_ports[base+p] == dport) return;
        if (c < PORTS_PER_ENTRY) begin
          seen_ports[base+c] = dport;
          tab_ports[i] = c + 1;
        end
        return;
      end
    end
    if (free_slot < 0) begin
      push(psd_pkg::KIND_DROP, '0, '0, '0, 1'b1);
      return;
    end
    tab_valid[free_slot] = 1'b1;
    tab_dst[free_slot]   = dst;
    tab_src[free_slot]   = src;
    tab_udp[free_slot]   = udp;
    tab_ports[free_slot] = 1;
    tab_web[free_slot]   = 1;
    seen_ports[free_slot*PORTS_PER_ENTRY] = dport;
  endfunction

  always @(posedge clk) begin
    psd_pkg::result_t want, got;
    if (rst) begin
      regs <= '{watch_mode: 2'd0, my_addr: 32'd0, port_limit: 16'd7,
                web_limit: 16'd40, report_scans: 1'b1};
      foreach (tab_valid[i]) tab_valid[i] = 1'b0;
      alerts_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          psd_pkg::REG_WATCH_MODE:   regs.watch_mode   <= cfg_data[1:0];
          psd_pkg::REG_MY_ADDR:      regs.my_addr      <= cfg_data;
          psd_pkg::REG_PORT_LIMIT:   regs.port_limit   <= cfg_data[15:0];
          psd_pkg::REG_WEB_LIMIT:    regs.web_limit    <= cfg_data[15:0];
          psd_pkg::REG_REPORT_SCANS: regs.report_scans <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) scan_packet(s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind = m_tdata[1:0]; got.alert_src = m_tdata[33:2];
        got.alert_dst = m_tdata[65:34]; got.port_count = m_tdata[73:66];
        got.last = m_tlast;
        if (alerts_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %p", got);
        end else begin
          want = alerts_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

endmodule

/* bench/tb.sv */
// Testbench top for the port scan detector: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [79:0]  m_tdata;
  logic         m_tlast;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  int           errors, pending;
  int           stall_mode = 0;
  int           stall_count = 0;
  logic         no_gaps = 0;
  logic [31:0]  home;

  always #6 clk = ~clk;

  port_scan_detector_top dut (.*);

  psd_checker chk (.*);

  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count % 80 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 5) == 0);
      default: m_tready <= ((stall_count / 7) % 2 == 0);
    endcase
  end

  function automatic logic [111:0] word(logic op, logic ipv4, logic [7:0] proto,
      logic rst_flag, logic [31:0] src, logic [31:0] dst, logic [15:0] sp,
      logic [15:0] dp);
    return {5'd0, dp, sp, dst, src, rst_flag, proto, ipv4, op};
  endfunction

  task automatic send(logic [111:0] w);
    int gap;
    s_tdata  <= w;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic setup(logic [1:0] m, logic [31:0] a, logic [15:0] pl,
                       logic [15:0] wl, logic rs);
    write_reg(psd_pkg::REG_WATCH_MODE, 32'(m));
    write_reg(psd_pkg::REG_MY_ADDR, a);
    write_reg(psd_pkg::REG_PORT_LIMIT, 32'(pl));
    write_reg(psd_pkg::REG_WEB_LIMIT, 32'(wl));
    write_reg(psd_pkg::REG_REPORT_SCANS, 32'(rs));
  endtask

  function automatic logic [111:0] pick_item(int n_src);
    logic [31:0] src, dst;
    logic [15:0] sp, dp;
    logic [7:0]  proto;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return word(1'b1, 1'($urandom), 8'($urandom), 1'($urandom), $urandom,
                           $urandom, 16'($urandom), 16'($urandom));
    if (r < 14) return word(1'b0, 1'($urandom), 8'($urandom), 1'($urandom), $urandom,
                            $urandom, 16'($urandom), 16'($urandom));
    src = 32'hc0a80000 + $urandom_range(0, n_src - 1);
    if (n_src > 10 && $urandom_range(0, 9) == 0) src = $urandom;
    case ($urandom_range(0, 3))
      0, 1: dst = home;
      2: dst = {home[31:8], 8'($urandom)};
      default: dst = $urandom;
    endcase
    sp = ($urandom_range(0, 2) == 0) ? psd_pkg::WEB_PORT : 16'($urandom);
    dp = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
    proto = $urandom_range(0, 1) ? psd_pkg::PROTO_TCP : psd_pkg::PROTO_UDP;
    return word(1'b0, ($urandom_range(0, 19) != 0), proto, ($urandom_range(0, 9) == 0),
                src, dst, sp, dp);
  endfunction

  initial begin
    logic [31:0] a;
    int n_src, burst;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    a = 32'h0a000005;
    write_reg(psd_pkg::REG_MY_ADDR, a);
    send(word(1'b0, 1'b0, psd_pkg::PROTO_TCP, 1'b0, 32'h01010101, a, 16'd1, 16'd2));
    send(word(1'b0, 1'b1, psd_pkg::PROTO_UDP, 1'b0, 32'h01010101, 32'h0a000006,
              16'd1, 16'd2));
    send(word(1'b0, 1'b1, psd_pkg::PROTO_TCP, 1'b1, 32'h01010101, a, 16'd1, 16'd2));
    send(word(1'b0, 1'b1, 8'd1, 1'b0, 32'h01010101, a, 16'd1, 16'd2));
    send(word(1'b0, 1'b1, psd_pkg::PROTO_TCP, 1'b0, 32'h01010101, a,
              psd_pkg::WEB_PORT, 16'd0));
    send(word(1'b0, 1'b1, psd_pkg::PROTO_TCP, 1'b0, 32'h01010101, a,
              psd_pkg::WEB_PORT, 16'hffff));
    send(word(1'b0, 1'b1, psd_pkg::PROTO_TCP, 1'b0, 32'h01010101, a, 16'd5, 16'hffff));
    send(word(1'b0, 1'b1, psd_pkg::PROTO_UDP, 1'b0, 32'h01010101, a, 16'd0, 16'd0));
    send(word(1'b0, 1'b1, psd_pkg::PROTO_TCP, 1'b0, 32'hffffffff, a, 16'hffff, 16'd9));
    send(word(1'b1, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, 16'd0, 16'd0));
    for (int i = 0; i < 18; i++)
      send(word(1'b0, 1'b1, psd_pkg::PROTO_UDP, 1'b0, 32'h02020202, a, 16'd7,
                16'(i * 3000)));
    send(word(1'b1, 1'b1, 8'hff, 1'b1, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      home = $urandom;
      n_src = 6;
      case (ph)
        0: setup(2'd0, home, 16'd0, 16'd0, 1'b1);
        1: setup(2'd1, home, 16'd3, 16'd2, 1'b1);
        2: begin home = 32'hffffffff; setup(2'd2, home, 16'hffff, 16'hffff, 1'b1); end
        3: setup(2'd3, home, 16'd5, 16'd3, 1'b0);
        default: begin n_src = 48; setup(2'd2, home, 16'd7, 16'd40, 1'b1); end
      endcase
      no_gaps = (ph == 2);
      for (int i = 0; i < 72; i += burst) begin
        burst = $urandom_range(1, 8);
        for (int j = 0; j < burst; j++) send(pick_item(n_src));
        if (!no_gaps) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
      send(word(1'b1, 1'b0, 8'd0, 1'b0, 32'd0, 32'd0, 16'd0, 16'd0));
      drain();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
